>>> src/pdb_pkg.sv
// shared types and constants for the pixel depth backprojection block
package pdb_pkg;

    localparam int DIV_STEPS = 41;
    localparam int NUM_W     = 41;
    localparam int REM_W     = 16;
    localparam int CAM_W     = 42;
    localparam int ACC_W     = 60;

    typedef enum logic [2:0] {
        CFG_FOCAL    = 3'd0,
        CFG_PRINCIPAL = 3'd1,
        CFG_ROT0     = 3'd2,
        CFG_ROT1     = 3'd3,
        CFG_ROT2     = 3'd4,
        CFG_POS      = 3'd5,
        CFG_LIMITS   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] prod_x;
        logic [31:0] prod_y;
        logic        neg_x;
        logic        neg_y;
        logic [15:0] depth;
        logic        ok;
    } t_front;

    typedef struct packed {
        logic [REM_W-1:0] rem_x;
        logic [NUM_W-1:0] nq_x;
        logic [REM_W-1:0] rem_y;
        logic [NUM_W-1:0] nq_y;
        logic             neg_x;
        logic             neg_y;
        logic [15:0]      depth;
        logic             ok;
    } t_cell;

endpackage

>>> src/pixel_depth_backprojection_top.sv
// top level: config registers, front stage, divider cell chain, rotation
// Back-projects a pixel with depth to a world point. One request is taken
// every clock when the output side keeps up. The datapath is made of one
// offset-times-depth stage, a chain of 41 divide cells that each produce one
// bit of the rounded |u-cx|*d*256/fx and its y counterpart, and four stages of
// rotation, rounding, position add and saturation. Stages without a request
// fill up while the output waits. Configuration must be written while idle.
module pixel_depth_backprojection_top
    import pdb_pkg::*;
#(
    parameter int OUT_WIDTH = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // pixel_u, pixel_v, depth_mm
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [((3*OUT_WIDTH+7)/8)*8-1:0] m_axis_tdata,  // world_x, world_y, world_z
    output logic        m_axis_tuser,  // point_valid
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);
    localparam int TDW = ((3*OUT_WIDTH+7)/8)*8;

    logic [31:0] r_focal;
    logic [31:0] r_principal;
    logic [47:0] r_rot0;
    logic [47:0] r_rot1;
    logic [47:0] r_rot2;
    logic [47:0] r_pos;
    logic [31:0] r_limits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal     <= 32'd536879104;
            r_principal <= '0;
            r_rot0      <= 48'd16384;
            r_rot1      <= 48'd1073741824;
            r_rot2      <= 48'd70368744177664;
            r_pos       <= '0;
            r_limits    <= 32'hFFFF0000;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FOCAL:     r_focal     <= i_cfg_data[31:0];
                CFG_PRINCIPAL: r_principal <= i_cfg_data[31:0];
                CFG_ROT0:      r_rot0      <= i_cfg_data;
                CFG_ROT1:      r_rot1      <= i_cfg_data;
                CFG_ROT2:      r_rot2      <= i_cfg_data;
                CFG_POS:       r_pos       <= i_cfg_data;
                CFG_LIMITS:    r_limits    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic   w_f_valid;
    logic   w_f_ready;
    t_front w_f_data;
    logic   w_c_valid [DIV_STEPS+1];
    logic   w_c_ready [DIV_STEPS+1];
    t_cell  w_c_data  [DIV_STEPS+1];

    pdb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_u         (s_axis_tdata[15:0]),
        .i_v         (s_axis_tdata[31:16]),
        .i_d         (s_axis_tdata[47:32]),
        .i_focal     (r_focal),
        .i_principal (r_principal),
        .i_limits    (r_limits),
        .o_valid     (w_f_valid),
        .i_ready     (w_f_ready),
        .o_data      (w_f_data)
    );

    always_comb begin
        w_c_valid[0]       = w_f_valid;
        w_f_ready          = w_c_ready[0];
        w_c_data[0].rem_x  = '0;
        w_c_data[0].rem_y  = '0;
        w_c_data[0].nq_x   = {1'b0, w_f_data.prod_x, 8'd0} + NUM_W'(r_focal[15:1]);
        w_c_data[0].nq_y   = {1'b0, w_f_data.prod_y, 8'd0} + NUM_W'(r_focal[31:17]);
        w_c_data[0].neg_x  = w_f_data.neg_x;
        w_c_data[0].neg_y  = w_f_data.neg_y;
        w_c_data[0].depth  = w_f_data.depth;
        w_c_data[0].ok     = w_f_data.ok;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
        pdb_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_c_valid[k]),
            .o_ready (w_c_ready[k]),
            .i_data  (w_c_data[k]),
            .i_fx    (r_focal[15:0]),
            .i_fy    (r_focal[31:16]),
            .o_valid (w_c_valid[k+1]),
            .i_ready (w_c_ready[k+1]),
            .o_data  (w_c_data[k+1])
        );
    end

    logic signed [CAM_W-1:0]     w_cam_x;
    logic signed [CAM_W-1:0]     w_cam_y;
    logic signed [OUT_WIDTH-1:0] w_x;
    logic signed [OUT_WIDTH-1:0] w_y;
    logic signed [OUT_WIDTH-1:0] w_z;

    assign w_cam_x = w_c_data[DIV_STEPS].neg_x ? -CAM_W'(w_c_data[DIV_STEPS].nq_x)
                                               : CAM_W'(w_c_data[DIV_STEPS].nq_x);
    assign w_cam_y = w_c_data[DIV_STEPS].neg_y ? -CAM_W'(w_c_data[DIV_STEPS].nq_y)
                                               : CAM_W'(w_c_data[DIV_STEPS].nq_y);

    pdb_rotate #(.OUT_WIDTH(OUT_WIDTH)) u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c_valid[DIV_STEPS]),
        .o_ready (w_c_ready[DIV_STEPS]),
        .i_cam_x (w_cam_x),
        .i_cam_y (w_cam_y),
        .i_depth (w_c_data[DIV_STEPS].depth),
        .i_ok    (w_c_data[DIV_STEPS].ok),
        .i_rot0  (r_rot0),
        .i_rot1  (r_rot1),
        .i_rot2  (r_rot2),
        .i_pos   (r_pos),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_x     (w_x),
        .o_y     (w_y),
        .o_z     (w_z),
        .o_ok    (m_axis_tuser)
    );

    assign m_axis_tdata = TDW'({w_z, w_y, w_x});

    // invalid points leave as zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("invalid point with nonzero coordinates");

    // an empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // nothing leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

>>> src/pdb_front.sv
// offset from principal point times depth, and the validity check
module pdb_front
    import pdb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_u,
    input  logic [15:0] i_v,
    input  logic [15:0] i_d,
    input  logic [31:0] i_focal,
    input  logic [31:0] i_principal,
    input  logic [31:0] i_limits,
    output logic        o_valid,
    input  logic        i_ready,
    output t_front      o_data
);
    logic        r_v;
    t_front      r_d;
    t_front      n_d;
    logic        w_en;
    logic [16:0] w_dx;
    logic [16:0] w_dy;
    logic [15:0] w_ax;
    logic [15:0] w_ay;

    assign w_en    = !r_v || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v;
    assign o_data  = r_d;

    always_comb begin
        w_dx = {1'b0, i_u} - {1'b0, i_principal[15:0]};
        w_dy = {1'b0, i_v} - {1'b0, i_principal[31:16]};
        w_ax = w_dx[16] ? 16'(-w_dx) : w_dx[15:0];
        w_ay = w_dy[16] ? 16'(-w_dy) : w_dy[15:0];
        n_d.prod_x = w_ax * i_d;
        n_d.prod_y = w_ay * i_d;
        n_d.neg_x  = w_dx[16];
        n_d.neg_y  = w_dy[16];
        n_d.depth  = i_d;
        n_d.ok     = (i_focal[15:0] != 16'd0) && (i_focal[31:16] != 16'd0)
                     && (i_d > i_limits[15:0]) && (i_d < i_limits[31:16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
        if (w_en && i_valid) begin
            r_d <= n_d;
        end
    end
endmodule

>>> src/pdb_div_cell.sv
// one restoring divide step for the x and y quotients
module pdb_div_cell
    import pdb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cell       i_data,
    input  logic [15:0] i_fx,
    input  logic [15:0] i_fy,
    output logic        o_valid,
    input  logic        i_ready,
    output t_cell       o_data
);
    logic        r_v;
    t_cell       r_d;
    t_cell       n_d;
    logic        w_en;
    logic [16:0] w_tx;
    logic [16:0] w_ty;
    logic        w_gx;
    logic        w_gy;

    assign w_en    = !r_v || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v;
    assign o_data  = r_d;

    always_comb begin
        w_tx = {i_data.rem_x, i_data.nq_x[NUM_W-1]};
        w_ty = {i_data.rem_y, i_data.nq_y[NUM_W-1]};
        w_gx = w_tx >= {1'b0, i_fx};
        w_gy = w_ty >= {1'b0, i_fy};
        n_d = i_data;
        n_d.rem_x = w_gx ? 16'(w_tx - {1'b0, i_fx}) : w_tx[15:0];
        n_d.rem_y = w_gy ? 16'(w_ty - {1'b0, i_fy}) : w_ty[15:0];
        n_d.nq_x  = {i_data.nq_x[NUM_W-2:0], w_gx};
        n_d.nq_y  = {i_data.nq_y[NUM_W-2:0], w_gy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
        if (w_en && i_valid) begin
            r_d <= n_d;
        end
    end
endmodule

>>> src/pdb_rotate.sv
// rotation, rounding, position offset and saturation
module pdb_rotate
    import pdb_pkg::*;
#(
    parameter int OUT_WIDTH = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [CAM_W-1:0]     i_cam_x,
    input  logic signed [CAM_W-1:0]     i_cam_y,
    input  logic [15:0]                 i_depth,
    input  logic                        i_ok,
    input  logic [47:0]                 i_rot0,
    input  logic [47:0]                 i_rot1,
    input  logic [47:0]                 i_rot2,
    input  logic [47:0]                 i_pos,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [OUT_WIDTH-1:0] o_x,
    output logic signed [OUT_WIDTH-1:0] o_y,
    output logic signed [OUT_WIDTH-1:0] o_z,
    output logic                        o_ok
);
    localparam logic signed [38:0] L_MAX = (39'sd1 <<< (OUT_WIDTH - 1)) - 39'sd1;
    localparam logic signed [38:0] L_MIN = -L_MAX - 39'sd1;

    logic [3:0] r_v;
    logic [3:0] w_en;
    logic [3:0] r_ok;

    logic signed [15:0]      w_r [3][3];
    logic signed [36:0]      r_hi [3][2];
    logic signed [37:0]      r_lo [3][2];
    logic signed [40:0]      r_pz [3];
    logic signed [ACC_W-1:0] r_el [3][3];
    logic signed [ACC_W-1:0] r_acc [3];
    logic signed [OUT_WIDTH-1:0] r_out [3];
    logic signed [20:0]      w_chi [2];
    logic signed [21:0]      w_clo [2];
    logic signed [24:0]      w_cz;

    assign w_en[3] = !r_v[3] || i_ready;
    assign w_en[2] = !r_v[2] || w_en[3];
    assign w_en[1] = !r_v[1] || w_en[2];
    assign w_en[0] = !r_v[0] || w_en[1];
    assign o_ready = w_en[0];
    assign o_valid = r_v[3];
    assign o_ok    = r_ok[3];
    assign o_x     = r_out[0];
    assign o_y     = r_out[1];
    assign o_z     = r_out[2];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_r[0][c] = i_rot0[16*c +: 16];
            w_r[1][c] = i_rot1[16*c +: 16];
            w_r[2][c] = i_rot2[16*c +: 16];
        end
        w_chi[0] = i_cam_x[CAM_W-1:21];
        w_chi[1] = i_cam_y[CAM_W-1:21];
        w_clo[0] = {1'b0, i_cam_x[20:0]};
        w_clo[1] = {1'b0, i_cam_y[20:0]};
        w_cz     = {1'b0, i_depth, 8'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            if (w_en[1]) r_v[1] <= r_v[0];
            if (w_en[2]) r_v[2] <= r_v[1];
            if (w_en[3]) r_v[3] <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0] && i_valid) begin
            r_ok[0] <= i_ok;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 2; c++) begin
                    r_hi[r][c] <= w_r[r][c] * w_chi[c];
                    r_lo[r][c] <= w_r[r][c] * w_clo[c];
                end
                r_pz[r] <= w_r[r][2] * w_cz;
            end
        end
        if (w_en[1] && r_v[0]) begin
            r_ok[1] <= r_ok[0];
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 2; c++) begin
                    r_el[r][c] <= (ACC_W'(r_hi[r][c]) <<< 21) + ACC_W'(r_lo[r][c]);
                end
                r_el[r][2] <= ACC_W'(r_pz[r]);
            end
        end
        if (w_en[2] && r_v[1]) begin
            r_ok[2] <= r_ok[1];
            for (int r = 0; r < 3; r++) begin
                r_acc[r] <= r_el[r][0] + r_el[r][1] + r_el[r][2]
                            + (ACC_W'(1) <<< 21);
            end
        end
        if (w_en[3] && r_v[2]) begin
            r_ok[3] <= r_ok[2];
            for (int r = 0; r < 3; r++) begin
                logic signed [38:0] s;
                s = 39'(r_acc[r] >>> 22) + 39'($signed(i_pos[16*r +: 16]));
                if (!r_ok[2]) begin
                    r_out[r] <= '0;
                end else if (s > L_MAX) begin
                    r_out[r] <= OUT_WIDTH'(L_MAX);
                end else if (s < L_MIN) begin
                    r_out[r] <= OUT_WIDTH'(L_MIN);
                end else begin
                    r_out[r] <= OUT_WIDTH'(s);
                end
            end
        end
    end
endmodule
